@@ rtl/core/itoa_pkg.sv @@
// itoa_pkg: shared types, constants and helpers for the radix conversion block
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BASE_W     = 5;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned STEPS      = VALUE_W / CHUNK_W;
  localparam int unsigned STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [BASE_W-1:0]  BASE_MIN     = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX     = BASE_W'(16);
  localparam logic [BASE_W-1:0]  DECIMAL      = BASE_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT  = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]  LETTER_BASE  = 8'h41;
  localparam logic [CHAR_W-1:0]  NUMERAL_BASE = 8'h30;
  localparam logic [CHAR_W-1:0]  MINUS_SIGN   = 8'h2D;
  localparam logic [CHAR_W-1:0]  TEN_CHAR     = 8'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
    logic [BASE_W-1:0]  base;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_step;
    logic q_zero;
    logic neg;
    logic one_left;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d > DIGIT_LIMIT) begin
      return dx - TEN_CHAR + LETTER_BASE;
    end
    return dx + NUMERAL_BASE;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/itoa_datapath.sv @@
// itoa_datapath: digit divider, digit stack and output word register
`default_nettype none

module itoa_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itoa_pkg::in_t   in_data_i,
  input  itoa_pkg::cmd_t  cmd_i,
  output itoa_pkg::sts_t  sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output itoa_pkg::out_t  out_data_o
);
  import itoa_pkg::*;

  logic [VALUE_W-1:0] q_q;
  logic [BASE_W-1:0]  rem_q;
  logic [BASE_W-1:0]  base_q;
  logic               neg_q;
  logic [STEP_W-1:0]  step_q;
  logic [CNT_W-1:0]   ndig_q;
  logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
  logic               out_valid_q;
  out_t               out_q;

  logic [BASE_W-1:0]  base_clamp;
  logic               neg_in;
  logic [VALUE_W-1:0] mag_in;
  logic [CHUNK_W-1:0] qbits;
  logic [BASE_W-1:0]  rem_next;
  logic [VALUE_W-1:0] q_next;
  logic [IDX_W-1:0]   push_idx;
  logic [IDX_W-1:0]   pop_idx;
  logic               last_step;

  always_comb begin
    base_clamp = in_data_i.base;
    if (in_data_i.base < BASE_MIN) begin
      base_clamp = BASE_MIN;
    end else if (in_data_i.base > BASE_MAX) begin
      base_clamp = BASE_MAX;
    end
    neg_in = in_data_i.is_signed && (base_clamp == DECIMAL) && in_data_i.value[VALUE_W-1];
    mag_in = neg_in ? (~in_data_i.value + VALUE_W'(1)) : in_data_i.value;
  end

  // one chunk of restoring division by the radix, msb first
  always_comb begin
    logic [BASE_W-1:0]  r;
    logic [CHUNK_W-1:0] chunk;
    r     = rem_q;
    chunk = q_q[VALUE_W-1 -: CHUNK_W];
    qbits = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      // remainder stays below the radix, so the top bit is free before the shift
      r = {r[BASE_W-2:0], chunk[CHUNK_W-1-i]};
      if (r >= base_q) begin
        r = r - base_q;
        qbits[CHUNK_W-1-i] = 1'b1;
      end
    end
    rem_next = r;
  end

  assign q_next    = {q_q[VALUE_W-CHUNK_W-1:0], qbits};
  assign last_step = (step_q == STEP_W'(STEPS - 1));
  assign push_idx  = ndig_q[IDX_W-1:0];
  assign pop_idx   = IDX_W'(ndig_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      ndig_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        neg_q  <= neg_in;
        step_q <= '0;
        ndig_q <= '0;
      end else if (cmd_i.step) begin
        step_q <= last_step ? '0 : step_q + STEP_W'(1);
        if (last_step) begin
          ndig_q <= ndig_q + CNT_W'(1);
        end
      end else if (cmd_i.emit_digit) begin
        ndig_q <= ndig_q - CNT_W'(1);
      end
      if (cmd_i.emit_sign) begin
        neg_q <= 1'b0;
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q    <= mag_in;
      rem_q  <= '0;
      base_q <= base_clamp;
    end else if (cmd_i.step) begin
      q_q   <= q_next;
      rem_q <= last_step ? '0 : rem_next;
      if (last_step) begin
        digits_q[push_idx] <= rem_next[DIGIT_W-1:0];
      end
    end
    if (cmd_i.emit_sign) begin
      out_q.char_out <= MINUS_SIGN;
      out_q.last     <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_q.char_out <= digit_char(digits_q[pop_idx]);
      out_q.last     <= (ndig_q == CNT_W'(1));
    end
  end

  assign sts_o.last_step = last_step;
  assign sts_o.q_zero    = (q_next == '0);
  assign sts_o.neg       = neg_q;
  assign sts_o.one_left  = (ndig_q == CNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/itoa_ctrl.sv @@
// itoa_ctrl: sequencer for load, digit division and character output
`default_nettype none

module itoa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itoa_pkg::sts_t sts_i,
  output itoa_pkg::cmd_t cmd_o
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;

  always_comb begin
    state_d    = state_q;
    in_ready_d = in_ready_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
          in_ready_d = 1'b0;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step && sts_i.q_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.neg) begin
            cmd_o.emit_sign = 1'b1;
          end else begin
            cmd_o.emit_digit = 1'b1;
            if (sts_i.one_left) begin
              state_d    = ST_IDLE;
              in_ready_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d    = ST_IDLE;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

`default_nettype wire

@@ rtl/core/integer_to_ascii_radix.sv @@
// integer_to_ascii_radix: top level of the integer to ascii text converter
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i / in_ready_o | value, is_signed, base
//  out     | output    | out_valid_o / out_ready_i | char_out, last
//
// one number at a time; each digit comes from a full pass of the shared divider
// over the value (8 quotient bits per cycle), then the characters go out
// one per cycle while the output is free
// 32-bit base 10 input: up to 11 characters, the sign included
// in_ready_o rises again as the last character is loaded into the output
// register; rst_ni clears the sequencer and the output valid at once
`default_nettype none

module integer_to_ascii_radix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  itoa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output itoa_pkg::out_t out_data_o
);
  import itoa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itoa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/itoa_checker.sv @@
// itoa_checker: port level assertions for the converter and their bind
`default_nettype none

module itoa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input itoa_pkg::out_t out_data_o
);
  import itoa_pkg::*;

  logic [CHAR_W-1:0] c;
  assign c = out_data_o.char_out;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // one number at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a number is in progress");

  // only the final character may wait while a new number is taken
  a_ready_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("ready while characters remain");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                    (c == MINUS_SIGN))
    else $error("character outside the digit set");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (c == MINUS_SIGN) |-> !out_data_o.last)
    else $error("minus sign flagged as last");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
